// ===== rtl/chunk_signature_carver_assert.svh =====
// Assertion macros for the chunk signature carver RTL.
// Included by modules that check their own logic; no other dependencies.
`ifndef CHUNK_SIGNATURE_CARVER_ASSERT_SVH
`define CHUNK_SIGNATURE_CARVER_ASSERT_SVH

`ifndef SYNTHESIS

// Check held at every clock edge outside reset.
`define CSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("carver assertion failed");

// Check held at every clock edge, reset included.
`define CSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("carver assertion failed");

`else

`define CSC_ASSERT(lbl, clk, rst, prop)
`define CSC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/csc_pkg.sv =====
// Shared types, constants and helpers for the chunk signature carver.
// No dependencies.
package csc_pkg;

  localparam int INDEX_BITS = 16;
  localparam logic [31:0] SIG_DEFAULT = 32'h4D54_6864; // "MThd"

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        in_file;
    logic        file_start;
    logic [15:0] file_number;
    logic        last;
  } csc_result_t;

  // Zero-based file index, truncated or zero-extended to 16 bits.
  function automatic logic [15:0] file_index(input logic active,
                                             input logic [INDEX_BITS:0] count);
    logic [INDEX_BITS:0]    cm1;
    logic [INDEX_BITS+16:0] wide;
    begin
      cm1  = (active && (count != '0)) ? (count - 1'b1) : '0;
      wide = (INDEX_BITS+17)'(cm1);
      return wide[15:0];
    end
  endfunction

endpackage

// ===== rtl/csc_core.sv =====
// Carver core: signature search, length parse, skip count, delay line and flush.
// Depends on csc_pkg and chunk_signature_carver_assert.svh.
`include "chunk_signature_carver_assert.svh"

module csc_core import csc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  byte_in,
  input  logic        last_in,
  input  logic        full,
  output logic        flushing,
  output logic        push,
  output csc_result_t res
);

  typedef enum logic [1:0] {PH_SEARCH, PH_LENGTH, PH_SKIP} phase_t;

  logic [31:0]         signature;
  logic [7:0]          delay_line [3];
  logic [7:0]          delay_line_next [3];
  logic [1:0]          fill, fill_next;
  logic [1:0]          elig, elig_next;
  phase_t              phase, phase_next;
  logic [31:0]         length_accum, length_accum_next;
  logic [31:0]         skip_remaining, skip_remaining_next;
  logic [INDEX_BITS:0] file_count, file_count_next;
  logic                inside_file, inside_file_next;
  logic [1:0]          flush_left, flush_left_next;
  logic [1:0]          flush_idx, flush_idx_next;

  logic        searching;
  logic        match;
  logic [31:0] win;
  logic [31:0] accum_shift;
  logic [31:0] rem_dec;

  assign flushing    = (flush_left != 2'd0);
  assign searching   = (phase != PH_LENGTH) && (phase != PH_SKIP);
  assign win         = {delay_line[0], delay_line[1], delay_line[2], byte_in};
  assign match       = searching && (fill == 2'd3) && (elig == 2'd3) && (win == signature);
  assign accum_shift = {length_accum[23:0], byte_in};
  assign rem_dec     = skip_remaining - 32'd1;

  always_comb begin
    delay_line_next     = delay_line;
    fill_next           = fill;
    elig_next           = elig;
    phase_next          = phase;
    length_accum_next   = length_accum;
    skip_remaining_next = skip_remaining;
    file_count_next     = file_count;
    inside_file_next    = inside_file;
    flush_left_next     = flush_left;
    flush_idx_next      = flush_idx;
    push                = 1'b0;
    res                 = '0;

    if (accept) begin
      if (match) begin
        inside_file_next    = 1'b1;
        if (!file_count[INDEX_BITS]) file_count_next = file_count + 1'b1;
        phase_next          = PH_LENGTH;
        skip_remaining_next = 32'd4;
        length_accum_next   = '0;
        elig_next           = 2'd0;
      end else begin
        unique case (phase)
          PH_LENGTH: begin
            length_accum_next   = accum_shift;
            skip_remaining_next = rem_dec;
            if (rem_dec == 32'd0) begin
              skip_remaining_next = accum_shift;
              phase_next = (accum_shift == 32'd0) ? PH_SEARCH : PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (skip_remaining != 32'd0) skip_remaining_next = rem_dec;
            if (skip_remaining <= 32'd1) phase_next = PH_SEARCH;
          end
          default: begin
            phase_next = PH_SEARCH;
            if (elig != 2'd3) elig_next = elig + 2'd1;
          end
        endcase
      end

      if (fill == 2'd3) begin
        push             = 1'b1;
        res.byte_val     = delay_line[0];
        res.in_file      = inside_file_next;
        res.file_start   = match;
        res.file_number  = file_index(inside_file_next, file_count_next);
        res.last         = 1'b0;
        delay_line_next[0] = delay_line[1];
        delay_line_next[1] = delay_line[2];
        delay_line_next[2] = byte_in;
      end else begin
        delay_line_next[fill] = byte_in;
        fill_next = fill + 2'd1;
      end

      if (last_in) begin
        flush_left_next = (fill == 2'd3) ? 2'd3 : fill + 2'd1;
        flush_idx_next  = 2'd0;
      end
    end else if (flushing && !full) begin
      // drain held bytes with state frozen, then return to reset state
      push            = 1'b1;
      res.byte_val    = delay_line[flush_idx];
      res.in_file     = inside_file;
      res.file_start  = 1'b0;
      res.file_number = file_index(inside_file, file_count);
      res.last        = (flush_left == 2'd1);
      flush_left_next = flush_left - 2'd1;
      flush_idx_next  = flush_idx + 2'd1;
      if (flush_left == 2'd1) begin
        fill_next        = 2'd0;
        elig_next        = 2'd0;
        phase_next       = PH_SEARCH;
        file_count_next  = '0;
        inside_file_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signature   <= SIG_DEFAULT;
      fill        <= 2'd0;
      elig        <= 2'd0;
      phase       <= PH_SEARCH;
      file_count  <= '0;
      inside_file <= 1'b0;
      flush_left  <= 2'd0;
      flush_idx   <= 2'd0;
    end else begin
      if (cfg_write) signature <= cfg_data;
      fill        <= fill_next;
      elig        <= elig_next;
      phase       <= phase_next;
      file_count  <= file_count_next;
      inside_file <= inside_file_next;
      flush_left  <= flush_left_next;
      flush_idx   <= flush_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    delay_line     <= delay_line_next;
    length_accum   <= length_accum_next;
    skip_remaining <= skip_remaining_next;
  end

  `CSC_ASSERT(a_no_accept_in_flush, clk, rst, flushing |-> !accept)
  `CSC_ASSERT(a_last_starts_flush, clk, rst, (accept && last_in) |=> flushing)
  `CSC_ASSERT(a_start_in_file, clk, rst, (push && res.file_start) |-> res.in_file)
  `CSC_ASSERT(a_no_overflow, clk, rst, push |-> !full)

endmodule

// ===== rtl/csc_out_fifo.sv =====
// Two-entry result queue that decouples the core from the output handshake.
// Depends on csc_pkg.
module csc_out_fifo import csc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  csc_result_t push_data,
  input  logic        pop,
  output logic        full,
  output logic        valid,
  output csc_result_t head
);

  csc_result_t mem [2];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count, count_next;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/chunk_signature_carver.sv =====
// Top level of the chunk signature carver.
// Depends on csc_pkg, csc_core and csc_out_fifo.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one stream byte per request
//    with last_in on the final byte. Output channel (out_valid/out_stall)
//    carries one classified byte per request.
//  - Bytes pass through a 3-byte delay: the result for a byte is pushed when
//    the third byte after it is accepted, and is registered in the result queue.
//  - Throughput is one byte per cycle when not stalled; the core handles each
//    byte in a single registered pass (one 32-bit compare plus counter updates).
//  - A request with last_in set drains the 1 to 3 held bytes, one per cycle
//    while the queue is not full, with in_stall high; the final one carries
//    last_out. All stream state then returns to its reset value.
//  - A two-entry result queue sits between core and output; in_stall rises
//    when that queue is full or a held-byte drain is running, so a stalled
//    receiver holds results and input stops two results later.
//  - cfg_write loads the signature register (first byte in bits 31..24);
//    write only while the block is idle.
//  - rst (synchronous) sets the signature to "MThd", clears all stream
//    state and empties the queue.
module chunk_signature_carver import csc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic        in_file,
  output logic        file_start,
  output logic [15:0] file_number,
  output logic        last_out
);

  logic        accept;
  logic        pop;
  logic        full;
  logic        flushing;
  logic        push;
  csc_result_t res;
  csc_result_t head;

  // Stall is registered state only: queue full or held-byte drain running.
  assign in_stall = full || flushing;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  csc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .byte_in   (byte_in),
    .last_in   (last_in),
    .full      (full),
    .flushing  (flushing),
    .push      (push),
    .res       (res)
  );

  csc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .full      (full),
    .valid     (out_valid),
    .head      (head)
  );

  assign byte_out    = head.byte_val;
  assign in_file     = head.in_file;
  assign file_start  = head.file_start;
  assign file_number = head.file_number;
  assign last_out    = head.last;

endmodule
